/* hw/rtl/scs1_pkg.sv */
// Shared types, codes and scancode translation tables for the set-1 event queue.
// No dependencies; used by every module of the block except scs1_ram.
package scs1_pkg;

  localparam logic [7:0] PREFIX_EXT   = 8'hE0;
  localparam logic [7:0] PREFIX_PAUSE = 8'hE1;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ENTRY_W = CODE_W + 1;

  typedef struct packed {
    logic              push;
    logic [CODE_W-1:0] code;
    logic              pressed;
  } scs1_event_t;

  function automatic logic [CODE_W-1:0] base_code(input logic [6:0] key);
    logic [CODE_W-1:0] code;
    code = '0;
    unique case (key)
      7'd84:   code = 8'd99;
      7'd85:   code = 8'd84;
      7'd86:   code = 8'd86;
      7'd87:   code = 8'd87;
      7'd88:   code = 8'd88;
      7'd89:   code = 8'd85;
      7'd91:   code = 8'd125;
      7'd92:   code = 8'd126;
      7'd93:   code = 8'd127;
      7'd94:   code = 8'd116;
      7'd95:   code = 8'd142;
      7'd99:   code = 8'd143;
      default: code = (key < 7'd84) ? {1'b0, key} : 8'd0;
    endcase
    return code;
  endfunction

  function automatic logic [CODE_W-1:0] ext_code(input logic [6:0] key);
    logic [CODE_W-1:0] code;
    code = '0;
    unique case (key)
      7'h1C:   code = 8'd96;
      7'h1D:   code = 8'd97;
      7'h35:   code = 8'd98;
      7'h37:   code = 8'd99;
      7'h38:   code = 8'd100;
      7'h47:   code = 8'd102;
      7'h48:   code = 8'd103;
      7'h49:   code = 8'd104;
      7'h4B:   code = 8'd105;
      7'h4D:   code = 8'd106;
      7'h4F:   code = 8'd107;
      7'h50:   code = 8'd108;
      7'h51:   code = 8'd109;
      7'h52:   code = 8'd110;
      7'h53:   code = 8'd111;
      7'h5B:   code = 8'd125;
      7'h5C:   code = 8'd126;
      7'h5D:   code = 8'd127;
      7'h5E:   code = 8'd116;
      7'h5F:   code = 8'd142;
      7'h63:   code = 8'd143;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/scancode_set1_event_queue.sv */
// Set-1 scancode decoder with a queue of key events: top level.
// Usage: the slave channel carries requests. tuser selects the kind: 0 is a
// scancode byte in tdata[7:0], 1 is a poll for the oldest queued event.
// Every accepted request gives exactly one transfer on the master channel.
// 0xE0 arms the extension prefix, 0xE1 is ignored, any other byte is
// translated to a keycode and, if nonzero, queued with its pressed bit. The
// ring holds RING_DEPTH-1 events; an event that finds it full is discarded
// and the result of that byte has event_dropped set.
// A poll result has tuser set when an event was popped, with the keycode and
// pressed bit in tdata; otherwise those fields are zero.
// An accepted request passes through one input register, then the decode, ROM
// lookup and ring update, then the result register, which also holds the
// registered read of the event store RAM.
// Throughput is one request per cycle; when the receiver stalls, the result
// holds and the input register still takes one more request.
// Reset empties the ring and clears the prefix; no clearing pass is needed.
module scancode_set1_event_queue #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] scan_byte
  input  logic        s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] key_code, [8] key_pressed, [9] event_dropped
  output logic        m_axis_tuser   // [0] event_valid
);

  logic       in_valid;
  logic       in_type;
  logic [7:0] in_byte;
  logic       advance;
  logic       fire;
  logic       out_valid;
  logic       ev_valid;
  logic       ev_dropped;
  logic       pop_ok;
  logic       drop;
  logic       is_scan;
  logic [scs1_pkg::ENTRY_W-1:0] rd_entry;
  scs1_pkg::scs1_event_t dec_evt;
  scs1_pkg::scs1_event_t ring_evt;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign is_scan       = (in_type == scs1_pkg::REQ_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_type <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  scs1_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (fire && is_scan),
    .scan_byte (in_byte),
    .evt       (dec_evt)
  );

  always_comb begin
    ring_evt      = dec_evt;
    ring_evt.push = dec_evt.push && fire && is_scan;
  end

  scs1_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .evt      (ring_evt),
    .pop_req  (fire && (in_type == scs1_pkg::REQ_POLL)),
    .pop_ok   (pop_ok),
    .dropped  (drop),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_valid   <= pop_ok;
      ev_dropped <= drop;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = ev_valid;
  assign m_axis_tdata  = {6'd0, ev_dropped, ev_valid & rd_entry[0],
                          ev_valid ? rd_entry[scs1_pkg::ENTRY_W-1:1] : 8'd0};

endmodule

/* hw/rtl/scs1_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module scs1_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/scs1_decode.sv */
// Scancode decoder: extension prefix flag and translation to keycodes.
// Depends on scs1_pkg.
module scs1_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          scan_byte,
  output scs1_pkg::scs1_event_t evt
);

  logic       prefix_pending;
  logic       prefix_pending_next;
  logic [6:0] key;
  logic [scs1_pkg::CODE_W-1:0] code;
  logic       is_ext;
  logic       is_pause;

  assign key      = scan_byte[6:0];
  assign is_ext   = (scan_byte == scs1_pkg::PREFIX_EXT);
  assign is_pause = (scan_byte == scs1_pkg::PREFIX_PAUSE);
  assign code     = prefix_pending ? scs1_pkg::ext_code(key) : scs1_pkg::base_code(key);

  always_comb begin
    prefix_pending_next = prefix_pending;
    if (is_ext) begin
      prefix_pending_next = 1'b1;
    end else if (!is_pause) begin
      prefix_pending_next = 1'b0;
    end
  end

  assign evt.push    = !is_ext && !is_pause && (code != '0);
  assign evt.code    = code;
  assign evt.pressed = !scan_byte[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pending <= 1'b0;
    end else if (advance) begin
      prefix_pending <= prefix_pending_next;
    end
  end

endmodule

/* hw/rtl/scs1_ring.sv */
// Event ring: write and read pointers around the event store RAM.
// Depends on scs1_pkg and scs1_ram.
module scs1_ring #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scs1_pkg::scs1_event_t         evt,
  input  logic                          pop_req,
  output logic                          pop_ok,
  output logic                          dropped,
  output logic [scs1_pkg::ENTRY_W-1:0]  rd_entry
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] write_pointer_next;
  logic [PTR_W-1:0] read_pointer_next;
  logic             empty;
  logic             full;
  logic             push_ok;

  assign write_pointer_next = (write_pointer == PTR_W'(RING_DEPTH - 1)) ?
                              '0 : write_pointer + 1'b1;
  assign read_pointer_next  = (read_pointer == PTR_W'(RING_DEPTH - 1)) ?
                              '0 : read_pointer + 1'b1;

  assign empty   = (write_pointer == read_pointer);
  assign full    = (write_pointer_next == read_pointer);
  assign pop_ok  = pop_req && !empty;
  assign push_ok = evt.push && !full;
  assign dropped = evt.push && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
    end else begin
      if (push_ok) begin
        write_pointer <= write_pointer_next;
      end
      if (pop_ok) begin
        read_pointer <= read_pointer_next;
      end
    end
  end

  scs1_ram #(
    .WIDTH (scs1_pkg::ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push_ok),
    .waddr (write_pointer),
    .wdata ({evt.code, evt.pressed}),
    .re    (pop_ok),
    .raddr (read_pointer),
    .rdata (rd_entry)
  );

endmodule
